/* rtl/core/fla_pkg.sv */
// ----------------------------------------------------------------------------
// fla_pkg: shared types and constants of the free list allocator
// Beat structs, status and policy codes, and the segment table command.
// ----------------------------------------------------------------------------
package fla_pkg;

  // header bytes in front of every payload
  localparam logic [15:0] HDR_BYTES = 16'd4;
  // arena size after reset
  localparam logic [14:0] MEM_SIZE_RESET = 15'd32767;

  // configuration register indexes
  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_MEMSIZE = 2'd1;

  // request codes
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  // allocation policy codes
  localparam logic [1:0] POL_BEST  = 2'd0;
  localparam logic [1:0] POL_FIRST = 2'd1;
  localparam logic [1:0] POL_NEXT  = 2'd2;
  localparam logic [1:0] POL_RSVD  = 2'd3;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic        func;
    logic [14:0] req_size;
    logic [14:0] block_address;
  } fla_in_t;

  typedef struct packed {
    logic [14:0] granted_address;
    logic [1:0]  status;
    logic [5:0]  segment_count;
    logic [14:0] largest_free;
  } fla_out_t;

  // segment table operations
  typedef enum logic [2:0] {
    SEG_NOP,
    SEG_INIT,
    SEG_WRITE,
    SEG_WLEN,
    SEG_REMOVE,
    SEG_MERGE,
    SEG_INSERT,
    SEG_ROTATE
  } seg_op_t;

  typedef struct packed {
    seg_op_t     op;
    logic [14:0] start;
    logic [14:0] len;
  } seg_cmd_t;

endpackage

/* rtl/core/fla_seg_table.sv */
// ----------------------------------------------------------------------------
// fla_seg_table: ordered table of free segments
// Holds (start, length) pairs and the segment count. One command a cycle:
// write, insert with shift up, remove with shift down, merge, rotate by one.
// ----------------------------------------------------------------------------
module fla_seg_table #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fla_pkg::seg_cmd_t                 cmd,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]   cmd_idx,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]   rd_idx,
  output logic [14:0]                       rd_start,
  output logic [14:0]                       rd_len,
  output logic [$clog2(MAX_SEGMENTS+1)-1:0] count
);

  localparam int SIW = $clog2(MAX_SEGMENTS);
  localparam int SCW = $clog2(MAX_SEGMENTS + 1);

  logic [14:0]    start_r [MAX_SEGMENTS];
  logic [14:0]    len_r   [MAX_SEGMENTS];
  logic [SCW-1:0] count_r;

  assign rd_start = start_r[rd_idx];
  assign rd_len   = len_r[rd_idx];
  assign count    = count_r;

  // per entry next value
  for (genvar j = 0; j < MAX_SEGMENTS; j++) begin : g_ent
    logic [14:0] up_s, up_l, dn_s, dn_l, s_nxt, l_nxt;

    if (j < MAX_SEGMENTS - 1) begin : g_up
      assign up_s = start_r[j+1];
      assign up_l = len_r[j+1];
    end else begin : g_up_end
      assign up_s = start_r[j];
      assign up_l = len_r[j];
    end

    if (j > 0) begin : g_dn
      assign dn_s = start_r[j-1];
      assign dn_l = len_r[j-1];
    end else begin : g_dn_end
      assign dn_s = start_r[j];
      assign dn_l = len_r[j];
    end

    always_comb begin
      s_nxt = start_r[j];
      l_nxt = len_r[j];
      unique case (cmd.op)
        fla_pkg::SEG_INIT: begin
          if (j == 0) begin
            s_nxt = '0;
            l_nxt = cmd.len;
          end
        end
        fla_pkg::SEG_WRITE: begin
          if (SIW'(j) == cmd_idx) begin
            s_nxt = cmd.start;
            l_nxt = cmd.len;
          end
        end
        fla_pkg::SEG_WLEN: begin
          if (SIW'(j) == cmd_idx) l_nxt = cmd.len;
        end
        fla_pkg::SEG_REMOVE: begin
          if (SIW'(j) >= cmd_idx) begin
            s_nxt = up_s;
            l_nxt = up_l;
          end
        end
        fla_pkg::SEG_MERGE: begin
          if (SIW'(j) == cmd_idx) begin
            l_nxt = cmd.len;
          end else if (SIW'(j) > cmd_idx) begin
            s_nxt = up_s;
            l_nxt = up_l;
          end
        end
        fla_pkg::SEG_INSERT: begin
          if (SIW'(j) == cmd_idx) begin
            s_nxt = cmd.start;
            l_nxt = cmd.len;
          end else if (SIW'(j) > cmd_idx) begin
            s_nxt = dn_s;
            l_nxt = dn_l;
          end
        end
        fla_pkg::SEG_ROTATE: begin
          if (count_r >= SCW'(2)) begin
            if (SCW'(j) == count_r - SCW'(1)) begin
              s_nxt = start_r[0];
              l_nxt = len_r[0];
            end else if (SCW'(j) < count_r - SCW'(1)) begin
              s_nxt = up_s;
              l_nxt = up_l;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (j == 0) begin : g_head
      // the head entry carries the reset arena
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          start_r[j] <= '0;
          len_r[j]   <= fla_pkg::MEM_SIZE_RESET;
        end else begin
          start_r[j] <= s_nxt;
          len_r[j]   <= l_nxt;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        start_r[j] <= s_nxt;
        len_r[j]   <= l_nxt;
      end
    end
  end

  // segment count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= SCW'(1);
    end else begin
      unique case (cmd.op)
        fla_pkg::SEG_INIT:   count_r <= SCW'(cmd.len != '0);
        fla_pkg::SEG_REMOVE: count_r <= count_r - SCW'(1);
        fla_pkg::SEG_MERGE:  count_r <= count_r - SCW'(1);
        fla_pkg::SEG_INSERT: count_r <= count_r + SCW'(1);
        default:             count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/core/free_list_allocator_unit.sv */
// ----------------------------------------------------------------------------
// free_list_allocator_unit: free list allocator over a byte arena
// Sequencer that walks the segment and block tables one entry a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request beat (allocate or free), accepted on in_valid & !in_stall.
//   out_* : one result beat per request, taken on out_valid & !out_stall.
//   cfg_* : register writes (policy, arena size), taken on cfg_valid & cfg_ready,
//           only while no request is in flight.
// Steps: a request scans the block slots, up to MAX_BLOCKS, then walks the
//   segment table through its single read port. An allocate rotates the
//   table for next fit and carves the chosen segment; a free absorbs the
//   block into a neighbour (next fit) or inserts it and merges neighbours.
//   Both end with a scan for the largest free segment.
// in_stall is high while a request is being worked on. A finished result
//   waits in the output register; the next request may start meanwhile and
//   holds at its last step while that register is still full.
// Reset (synchronous, rst_n low): best fit, one free segment of 32767
//   bytes, no block allocated, no result pending.
// ----------------------------------------------------------------------------
module free_list_allocator_unit #(
  parameter int MAX_SEGMENTS = 32,
  parameter int MAX_BLOCKS   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fla_pkg::fla_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fla_pkg::fla_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [14:0]       cfg_data
);

  localparam int SIW = $clog2(MAX_SEGMENTS);
  localparam int SCW = $clog2(MAX_SEGMENTS + 1);
  localparam int BIW = $clog2(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE, S_BSCAN, S_SSCAN, S_ROT, S_CARVE, S_FNF, S_REMH,
    S_APPEND, S_INS, S_MLD, S_MRG, S_MAX
  } state_t;

  state_t            state_r;
  logic [1:0]        policy_r;
  logic              func_r;
  logic [15:0]       need_r;
  logic [14:0]       addr_r;
  logic [BIW-1:0]    bk_r, slot_r;
  logic [SCW-1:0]    sk_r;
  logic              found_r;
  logic [SIW-1:0]    pick_r, rot_r, ins_r, lo_r, hi_r;
  logic [14:0]       pick_len_r, seg_s_r, seg_l_r, lo_len_r, hi_len_r;
  logic              lo_f_r, hi_f_r;
  logic [14:0]       cur_s_r, cur_l_r, big_r, grant_r;
  fla_pkg::status_t  status_r;
  logic              out_valid_r;
  fla_pkg::fla_out_t out_data_r;

  logic [MAX_BLOCKS-1:0] blk_valid_r;
  logic [14:0]           blk_start_r [MAX_BLOCKS];
  logic [14:0]           blk_len_r   [MAX_BLOCKS];

  fla_pkg::seg_cmd_t cmd;
  logic [SIW-1:0]    cmd_idx, rd_idx;
  logic [14:0]       rd_start, rd_len;
  logic [SCW-1:0]    seg_cnt;

  fla_seg_table #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cmd_idx  (cmd_idx),
    .rd_idx   (rd_idx),
    .rd_start (rd_start),
    .rd_len   (rd_len),
    .count    (seg_cnt)
  );

  // handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !in_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic cfg_wr;
  assign cfg_wr = cfg_valid && cfg_ready;

  // shared datapath terms
  logic [SCW-1:0] sk1;
  logic [15:0]    rd_end, cur_end, seg_e, carve_len, blk_addr;
  logic [14:0]    merge_len, fnf_len;
  logic           scan_end, fit_hit, merge_hit, seg_full, out_free, out_load;
  logic [15:0]    cnt_ext;

  assign sk1       = sk_r + SCW'(1);
  assign rd_end    = {1'b0, rd_start} + {1'b0, rd_len};
  assign cur_end   = {1'b0, cur_s_r} + {1'b0, cur_l_r};
  assign seg_e     = {1'b0, seg_s_r} + {1'b0, seg_l_r};
  assign carve_len = {1'b0, rd_len} - need_r;
  assign blk_addr  = {1'b0, blk_start_r[bk_r]} + fla_pkg::HDR_BYTES;
  assign merge_len = cur_l_r + rd_len;
  assign fnf_len   = lo_len_r + seg_l_r + (hi_f_r ? hi_len_r : 15'd0);
  assign scan_end  = (sk_r == seg_cnt);
  assign fit_hit   = ({1'b0, rd_len} >= need_r);
  assign merge_hit = (cur_end == {1'b0, rd_start});
  assign seg_full  = (seg_cnt >= SCW'(MAX_SEGMENTS));
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_MAX) && scan_end && out_free;
  assign cnt_ext   = 16'(seg_cnt);

  // table read address
  always_comb begin
    unique case (state_r)
      S_SSCAN, S_MAX: rd_idx = sk_r[SIW-1:0];
      S_CARVE:        rd_idx = pick_r;
      S_MRG:          rd_idx = sk1[SIW-1:0];
      default:        rd_idx = '0;
    endcase
  end

  // table command
  always_comb begin
    cmd       = '{op: fla_pkg::SEG_NOP, start: '0, len: '0};
    cmd_idx   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_wr && cfg_index == fla_pkg::CFG_MEMSIZE) begin
          cmd.op  = fla_pkg::SEG_INIT;
          cmd.len = cfg_data;
        end
      end
      S_ROT: cmd.op = fla_pkg::SEG_ROTATE;
      S_CARVE: begin
        cmd_idx = pick_r;
        if (carve_len == '0) begin
          cmd.op = fla_pkg::SEG_REMOVE;
        end else begin
          cmd.op    = fla_pkg::SEG_WRITE;
          cmd.start = 15'({1'b0, rd_start} + need_r);
          cmd.len   = carve_len[14:0];
        end
      end
      S_FNF: begin
        if (lo_f_r) begin
          cmd.op  = fla_pkg::SEG_WLEN;
          cmd_idx = lo_r;
          cmd.len = fnf_len;
        end else if (hi_f_r) begin
          cmd.op  = fla_pkg::SEG_REMOVE;
          cmd_idx = hi_r;
        end
      end
      S_REMH: begin
        cmd.op  = fla_pkg::SEG_REMOVE;
        cmd_idx = hi_r;
      end
      S_APPEND, S_INS: begin
        cmd.op    = fla_pkg::SEG_INSERT;
        cmd_idx   = (state_r == S_APPEND) ? seg_cnt[SIW-1:0] : ins_r;
        cmd.start = seg_s_r;
        cmd.len   = seg_l_r;
      end
      S_MRG: begin
        if (sk1 < seg_cnt && merge_hit) begin
          cmd.op  = fla_pkg::SEG_MERGE;
          cmd_idx = sk_r[SIW-1:0];
          cmd.len = merge_len;
        end
      end
      default: begin
      end
    endcase
  end

  // block table payload: written at the granted slot
  always_ff @(posedge clk) begin
    if (state_r == S_CARVE) begin
      blk_start_r[slot_r] <= rd_start;
      blk_len_r[slot_r]   <= need_r[14:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= fla_pkg::POL_BEST;
      blk_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // hold the result beat until it is taken
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (cfg_wr) begin
            if (cfg_index == fla_pkg::CFG_POLICY) begin
              policy_r <= (cfg_data[1:0] == fla_pkg::POL_RSVD) ? fla_pkg::POL_BEST
                                                               : cfg_data[1:0];
            end else if (cfg_index == fla_pkg::CFG_MEMSIZE) begin
              blk_valid_r <= '0;
            end
          end else if (in_valid) begin
            func_r   <= in_data.func;
            need_r   <= {1'b0, in_data.req_size} + fla_pkg::HDR_BYTES;
            addr_r   <= in_data.block_address;
            bk_r     <= '0;
            grant_r  <= '0;
            status_r <= fla_pkg::ST_OK;
            state_r  <= S_BSCAN;
          end
        end

        // look for a free slot, or for the block being freed
        S_BSCAN: begin
          sk_r    <= '0;
          found_r <= 1'b0;
          lo_f_r  <= 1'b0;
          hi_f_r  <= 1'b0;
          big_r   <= '0;
          if (func_r == fla_pkg::FN_ALLOC && !blk_valid_r[bk_r]) begin
            slot_r  <= bk_r;
            state_r <= S_SSCAN;
          end else if (func_r == fla_pkg::FN_FREE && blk_valid_r[bk_r] &&
                       blk_addr == {1'b0, addr_r}) begin
            if (seg_full) begin
              status_r <= fla_pkg::ST_FULL;
              state_r  <= S_MAX;
            end else begin
              blk_valid_r[bk_r] <= 1'b0;
              seg_s_r <= blk_start_r[bk_r];
              seg_l_r <= blk_len_r[bk_r];
              state_r <= S_SSCAN;
            end
          end else if (bk_r == BIW'(MAX_BLOCKS - 1)) begin
            status_r <= (func_r == fla_pkg::FN_ALLOC) ? fla_pkg::ST_FULL
                                                      : fla_pkg::ST_BADFREE;
            state_r  <= S_MAX;
          end else begin
            bk_r <= bk_r + BIW'(1);
          end
        end

        // walk the segment table
        S_SSCAN: begin
          if (func_r == fla_pkg::FN_ALLOC) begin
            if (scan_end) begin
              if (!found_r) begin
                status_r <= fla_pkg::ST_NOSPACE;
                sk_r     <= '0;
                state_r  <= S_MAX;
              end else begin
                state_r <= S_CARVE;
              end
            end else if (policy_r == fla_pkg::POL_FIRST ||
                         policy_r == fla_pkg::POL_NEXT) begin
              if (fit_hit) begin
                pick_r <= sk_r[SIW-1:0];
                rot_r  <= sk_r[SIW-1:0];
                if (policy_r == fla_pkg::POL_NEXT && sk_r != '0) state_r <= S_ROT;
                else state_r <= S_CARVE;
              end else begin
                sk_r <= sk1;
              end
            end else begin
              if (fit_hit && (!found_r || rd_len < pick_len_r)) begin
                found_r    <= 1'b1;
                pick_r     <= sk_r[SIW-1:0];
                pick_len_r <= rd_len;
              end
              sk_r <= sk1;
            end
          end else if (policy_r == fla_pkg::POL_NEXT) begin
            if (scan_end) begin
              state_r <= S_FNF;
            end else begin
              if (!lo_f_r && rd_end == {1'b0, seg_s_r}) begin
                lo_f_r   <= 1'b1;
                lo_r     <= sk_r[SIW-1:0];
                lo_len_r <= rd_len;
              end
              if (!hi_f_r && {1'b0, rd_start} == seg_e) begin
                hi_f_r   <= 1'b1;
                hi_r     <= sk_r[SIW-1:0];
                hi_len_r <= rd_len;
              end
              sk_r <= sk1;
            end
          end else begin
            if (scan_end || rd_start > seg_s_r) begin
              ins_r   <= sk_r[SIW-1:0];
              state_r <= S_INS;
            end else begin
              sk_r <= sk1;
            end
          end
        end

        // move the head to the tail until the chosen segment leads
        S_ROT: begin
          rot_r <= rot_r - SIW'(1);
          if (rot_r == SIW'(1)) begin
            pick_r  <= '0;
            state_r <= S_CARVE;
          end
        end

        S_CARVE: begin
          blk_valid_r[slot_r] <= 1'b1;
          grant_r <= 15'({1'b0, rd_start} + fla_pkg::HDR_BYTES);
          sk_r    <= '0;
          state_r <= S_MAX;
        end

        // next fit: absorb into the lower neighbour or append at the tail
        S_FNF: begin
          sk_r <= '0;
          if (lo_f_r) begin
            state_r <= hi_f_r ? S_REMH : S_MAX;
          end else begin
            if (hi_f_r) seg_l_r <= seg_l_r + hi_len_r;
            state_r <= S_APPEND;
          end
        end

        S_REMH: begin
          sk_r    <= '0;
          state_r <= S_MAX;
        end

        S_APPEND: begin
          sk_r    <= '0;
          state_r <= S_MAX;
        end

        S_INS: begin
          sk_r    <= '0;
          state_r <= S_MLD;
        end

        S_MLD: begin
          cur_s_r <= rd_start;
          cur_l_r <= rd_len;
          state_r <= S_MRG;
        end

        // one merge pass over touching neighbours
        S_MRG: begin
          if (sk1 >= seg_cnt) begin
            sk_r    <= '0;
            state_r <= S_MAX;
          end else if (merge_hit) begin
            cur_l_r <= merge_len;
          end else begin
            sk_r    <= sk1;
            cur_s_r <= rd_start;
            cur_l_r <= rd_len;
          end
        end

        // largest segment, then hand the beat over
        S_MAX: begin
          if (scan_end) begin
            if (out_free) begin
              out_data_r.granted_address <= (status_r == fla_pkg::ST_OK) ? grant_r : '0;
              out_data_r.status          <= status_r;
              out_data_r.segment_count   <= cnt_ext[5:0];
              out_data_r.largest_free    <= big_r;
              state_r                    <= S_IDLE;
            end
          end else begin
            if (rd_len > big_r) big_r <= rd_len;
            sk_r <= sk1;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seg_cnt <= SCW'(MAX_SEGMENTS))
    else $error("segment count beyond table depth");

  a_cfg_init: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == fla_pkg::CFG_MEMSIZE
    |=> seg_cnt == SCW'($past(cfg_data) != 15'd0))
    else $error("arena reinit left wrong segment count");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != fla_pkg::ST_OK |-> out_data.granted_address == '0)
    else $error("failed request carries an address");

  a_ok_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CARVE |-> fit_hit)
    else $error("carving a segment that is too short");
`endif

endmodule

/* verif/free_list_allocator_unit_tb.sv */
// ----------------------------------------------------------------------------
// free_list_allocator_unit_tb: self-checking bench for the free list allocator
// Requests are queued by a stimulus process, driven by a clocked driver with
// random gaps, and every result beat is compared against an in-bench model
// of the segment and block tables under the configured fit policy.
// ----------------------------------------------------------------------------
module free_list_allocator_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG = 32;
  localparam int NBLK = 32;
  localparam int CYCLE_LIMIT = 2000000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  fla_pkg::fla_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  fla_pkg::fla_out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [14:0]       cfg_data = '0;

  free_list_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator model state
  logic [1:0]  m_policy;
  logic [14:0] m_memsize;
  int unsigned seg_s [NSEG];
  int unsigned seg_l [NSEG];
  int unsigned seg_n;
  int unsigned blk_s [NBLK];
  int unsigned blk_l [NBLK];
  bit          blk_v [NBLK];

  fla_pkg::fla_in_t  pending_reqs[$];
  fla_pkg::fla_out_t expected_results[$];
  int mismatches = 0;
  int cycles = 0;

  function automatic void arena_init();
    for (int k = 0; k < NBLK; k++) blk_v[k] = 1'b0;
    seg_s[0] = 0;
    seg_l[0] = 32'(m_memsize);
    seg_n = (m_memsize != 0) ? 1 : 0;
  endfunction

  function automatic void seg_remove(int unsigned idx);
    if (idx >= seg_n) return;
    for (int unsigned k = idx; k + 1 < seg_n; k++) begin
      seg_s[k] = seg_s[k+1];
      seg_l[k] = seg_l[k+1];
    end
    seg_n--;
  endfunction

  function automatic void seg_insert(int unsigned idx, int unsigned s, int unsigned l);
    if (seg_n >= NSEG || idx > seg_n) return;
    for (int unsigned k = seg_n; k > idx; k--) begin
      seg_s[k] = seg_s[k-1];
      seg_l[k] = seg_l[k-1];
    end
    seg_s[idx] = s;
    seg_l[idx] = l;
    seg_n++;
  endfunction

  function automatic void seg_rotate();
    int unsigned s, l;
    if (seg_n < 2) return;
    s = seg_s[0];
    l = seg_l[0];
    for (int unsigned k = 0; k + 1 < seg_n; k++) begin
      seg_s[k] = seg_s[k+1];
      seg_l[k] = seg_l[k+1];
    end
    seg_s[seg_n-1] = s;
    seg_l[seg_n-1] = l;
  endfunction

  function automatic fla_pkg::status_t carve_block(int unsigned req,
                                                   output int unsigned addr);
    int unsigned need, slot, start, k, tries;
    int pick;
    need = req + 4;
    slot = NBLK;
    pick = -1;
    addr = 0;
    for (k = 0; k < NBLK; k++)
      if (!blk_v[k]) begin
        slot = k;
        break;
      end
    if (slot == NBLK) return fla_pkg::ST_FULL;
    if (m_policy == fla_pkg::POL_NEXT) begin
      for (tries = 0; tries < seg_n; tries++) begin
        if (seg_l[0] >= need) begin
          pick = 0;
          break;
        end
        seg_rotate();
      end
    end else if (m_policy == fla_pkg::POL_FIRST) begin
      for (k = 0; k < seg_n; k++)
        if (seg_l[k] >= need) begin
          pick = k;
          break;
        end
    end else begin
      for (k = 0; k < seg_n; k++)
        if (seg_l[k] >= need && (pick < 0 || seg_l[k] < seg_l[pick])) pick = k;
    end
    if (pick < 0) return fla_pkg::ST_NOSPACE;
    start = seg_s[pick];
    seg_s[pick] = (start + need) & 15'h7fff;
    seg_l[pick] -= need;
    if (seg_l[pick] == 0) seg_remove(pick);
    blk_v[slot] = 1'b1;
    blk_s[slot] = start;
    blk_l[slot] = need;
    addr = (start + 4) & 15'h7fff;
    return fla_pkg::ST_OK;
  endfunction

  function automatic fla_pkg::status_t release_block(int unsigned addr);
    int unsigned slot, k, s, l, e;
    int lo, hi;
    slot = NBLK;
    lo = -1;
    hi = -1;
    for (k = 0; k < NBLK; k++)
      if (blk_v[k] && blk_s[k] + 4 == addr) begin
        slot = k;
        break;
      end
    if (slot == NBLK) return fla_pkg::ST_BADFREE;
    if (seg_n >= NSEG) return fla_pkg::ST_FULL;
    s = blk_s[slot];
    l = blk_l[slot];
    e = s + l;
    blk_v[slot] = 1'b0;
    if (m_policy == fla_pkg::POL_NEXT) begin
      for (k = 0; k < seg_n; k++) begin
        if (lo < 0 && seg_s[k] + seg_l[k] == s) lo = k;
        if (hi < 0 && seg_s[k] == e) hi = k;
      end
      if (lo >= 0) begin
        seg_l[lo] = (seg_l[lo] + l) & 15'h7fff;
        if (hi >= 0) begin
          seg_l[lo] = (seg_l[lo] + seg_l[hi]) & 15'h7fff;
          seg_remove(hi);
        end
      end else if (hi >= 0) begin
        l = (l + seg_l[hi]) & 15'h7fff;
        seg_remove(hi);
        seg_insert(seg_n, s, l);
      end else begin
        seg_insert(seg_n, s, l);
      end
    end else begin
      for (k = 0; k < seg_n; k++)
        if (seg_s[k] > s) break;
      seg_insert(k, s, l);
      k = 0;
      while (k + 1 < seg_n) begin
        if (seg_s[k] + seg_l[k] == seg_s[k+1]) begin
          seg_l[k] = (seg_l[k] + seg_l[k+1]) & 15'h7fff;
          seg_remove(k + 1);
        end else begin
          k++;
        end
      end
    end
    return fla_pkg::ST_OK;
  endfunction

  function automatic fla_pkg::fla_out_t predict_result(fla_pkg::fla_in_t req);
    fla_pkg::fla_out_t r;
    fla_pkg::status_t st;
    int unsigned granted, big;
    big = 0;
    if (req.func == fla_pkg::FN_ALLOC) st = carve_block(32'(req.req_size), granted);
    else begin
      st = release_block(32'(req.block_address));
      granted = 0;
    end
    if (st != fla_pkg::ST_OK) granted = 0;
    for (int unsigned k = 0; k < seg_n; k++)
      if (seg_l[k] > big) big = seg_l[k];
    r.granted_address = granted[14:0];
    r.status = st;
    r.segment_count = seg_n[5:0];
    r.largest_free = big[14:0];
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver: present queued beats with random gaps, predict on acceptance
  int unsigned in_gap = 0;
  bit hold_off = 1'b0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results = {expected_results, predict_result(in_data)};
        void'(pending_reqs.pop_front());
        in_gap = gap_len();
      end
      if (in_valid && in_stall) begin
        // hold stalled beat
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_off) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare result beats and stall at random
  int unsigned out_gap = 0;
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          fla_pkg::fla_out_t ex;
          ex = expected_results.pop_front();
          if (ex !== out_data) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", ex, out_data);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_gap = gap_len();
        out_stall <= 1'b0;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == fla_pkg::CFG_POLICY) begin
      m_policy = (val[1:0] == fla_pkg::POL_RSVD) ? fla_pkg::POL_BEST : val[1:0];
    end else begin
      m_memsize = val;
      arena_init();
    end
  endtask

  function automatic void queue_alloc(int unsigned sz);
    fla_pkg::fla_in_t r;
    r.func = fla_pkg::FN_ALLOC;
    r.req_size = sz[14:0];
    r.block_address = 15'($urandom());
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void queue_free(int unsigned a);
    fla_pkg::fla_in_t r;
    r.func = fla_pkg::FN_FREE;
    r.req_size = 15'($urandom());
    r.block_address = a[14:0];
    pending_reqs = {pending_reqs, r};
  endfunction

  // shadow of live payload offsets, for well-formed frees
  int unsigned live_addrs[$];

  // queue a random mix, a few beats ahead of the driver so that frees
  // can pick offsets that have already been granted
  task automatic random_phase(int n, int unsigned maxsz);
    for (int i = 0; i < n; i++) begin
      int unsigned p;
      while (pending_reqs.size() > 2) @(posedge clk);
      p = $urandom_range(0, 99);
      if (p < 50) queue_alloc($urandom_range(0, maxsz));
      else if (p < 90 && live_addrs.size() > 0) begin
        int unsigned j;
        j = $urandom_range(0, live_addrs.size() - 1);
        queue_free(live_addrs[j]);
        live_addrs.delete(j);
      end else if (p < 95) queue_free($urandom_range(0, 32767));
      else queue_alloc($urandom_range(0, 32763));
    end
  endtask

  // gather granted offsets by watching accepted results in order
  fla_pkg::fla_in_t acc_reqs[$];
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) acc_reqs = {acc_reqs, in_data};
    if (rst_n && out_valid && !out_stall && acc_reqs.size() > 0) begin
      fla_pkg::fla_in_t q;
      q = acc_reqs.pop_front();
      if (q.func == fla_pkg::FN_ALLOC && out_data.status == fla_pkg::ST_OK)
        live_addrs = {live_addrs, 32'(out_data.granted_address)};
    end
  end

  initial begin
    m_policy = fla_pkg::POL_BEST;
    m_memsize = fla_pkg::MEM_SIZE_RESET;
    arena_init();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, bad free, oversize, table exhaustion
    queue_alloc(0);
    queue_alloc(32763);
    queue_alloc(32762);
    queue_free(4);
    queue_free(0);
    queue_free(32767);
    queue_alloc(32763);
    drain();
    live_addrs.delete();
    write_reg(fla_pkg::CFG_POLICY, 15'(fla_pkg::POL_FIRST));
    write_reg(fla_pkg::CFG_MEMSIZE, 15'd3);
    queue_alloc(0);
    drain();
    write_reg(fla_pkg::CFG_MEMSIZE, 15'd0);
    queue_alloc(0);
    drain();
    write_reg(fla_pkg::CFG_POLICY, 15'(fla_pkg::POL_RSVD));
    write_reg(fla_pkg::CFG_MEMSIZE, 15'd4);
    queue_alloc(0);
    queue_free(4);
    drain();
    // fill the block table, then free alternate blocks to leave 17 separate free segments
    write_reg(fla_pkg::CFG_MEMSIZE, 15'd32767);
    live_addrs.delete();
    for (int i = 0; i < 33; i++) queue_alloc(4);
    drain();
    for (int i = 0; i < 32; i += 2) queue_free(4 + 8 * i);
    drain();
    live_addrs.delete();

    // random phases over all policies and arena sizes
    for (int ph = 0; ph < 12; ph++) begin
      logic [14:0] msz;
      int unsigned maxsz;
      case (ph % 4)
        0: msz = 15'd32767;
        1: msz = 15'($urandom_range(4, 600));
        2: msz = 15'($urandom_range(600, 32767));
        default: msz = 15'($urandom_range(4, 40));
      endcase
      write_reg(fla_pkg::CFG_POLICY, 15'(ph % 3));
      write_reg(fla_pkg::CFG_MEMSIZE, msz);
      live_addrs.delete();
      maxsz = (msz > 15'd40) ? 32'(msz) / 8 : 16;
      if (ph == 5) begin
        random_phase(55, maxsz);
        // pause the sender until everything outstanding has come back
        hold_off = 1'b1;
        @(posedge clk);
        while (in_valid || expected_results.size() > 0) @(posedge clk);
        hold_off = 1'b0;
        random_phase(55, maxsz);
      end else begin
        random_phase(110, maxsz);
      end
      drain();
    end
    drain();
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
rtl/core/fla_pkg.sv
rtl/core/fla_seg_table.sv
rtl/core/free_list_allocator_unit.sv
verif/free_list_allocator_unit_tb.sv
